/* hw/rtl/sv39pte_pkg.sv */
// Package for the Sv39 page table engine: transaction structs, status and
// operation codes, and fixed field widths. No dependencies.
package sv39pte_pkg;

    localparam int TABLE_PAGES_DEFAULT = 16;
    localparam int PT_ENTRIES          = 512;
    localparam int VPN_W               = 9;
    localparam int PAGE_SHIFT          = 12;
    localparam int PTE_PPN_SHIFT       = 10;
    localparam int LEVEL_TOP           = 3 - 1;
    localparam int PTE_W               = 64;
    localparam int VA_W                = 39;
    localparam int PA_W                = 56;
    localparam int PPN_W               = 44;
    localparam int COUNT_W             = 19;

    typedef logic [1:0] op_t;
    localparam op_t OP_MAP    = 2'd0;
    localparam op_t OP_UNMAP  = 2'd1;
    localparam op_t OP_LOOKUP = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_MISALIGNED  = 3'd1;
    localparam status_t ST_ZERO_COUNT  = 3'd2;
    localparam status_t ST_NO_MEMORY   = 3'd3;
    localparam status_t ST_REMAP       = 3'd4;
    localparam status_t ST_WALK_FAILED = 3'd5;
    localparam status_t ST_NOT_MAPPED  = 3'd6;
    localparam status_t ST_NOT_LEAF    = 3'd7;

    typedef struct packed {
        op_t                op;
        logic [VA_W-1:0]    virt_addr;
        logic [PA_W-1:0]    phys_addr;
        logic [COUNT_W-1:0] page_count;
        logic [7:0]         perm;
    } pte_req_t;

    typedef struct packed {
        status_t            status;
        logic [PA_W-1:0]    result_addr;
        logic [COUNT_W-1:0] pages_done;
    } pte_rsp_t;

endpackage

/* hw/rtl/sv39pte_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sv39pte_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/sv39_page_table_engine_top.sv */
// Sv39 page table engine: walk sequencer around one table RAM.
// Each page is walked one table level at a time, a read then a check per level; each
// allocated table page is first cleared by a sweep; errors found at acceptance answer without a walk.
// Flow: one transaction at a time; the next is accepted only after the result is taken.
// Reset: synchronous, active low; afterwards a sweep clears the root page, during which
// no transaction is accepted (configuration writes are).
// Depends on sv39pte_pkg and sv39pte_ram.
module sv39_page_table_engine_top #(
    parameter int TABLE_PAGES = sv39pte_pkg::TABLE_PAGES_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [sv39pte_pkg::PPN_W-1:0]     cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  sv39pte_pkg::pte_req_t             s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output sv39pte_pkg::pte_rsp_t             m_data
);

    localparam int PIDX_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int USED_W = $clog2(TABLE_PAGES + 1);
    localparam int VPN_W  = sv39pte_pkg::VPN_W;
    localparam int ADDR_W = PIDX_W + VPN_W;
    localparam int PPN_W  = sv39pte_pkg::PPN_W;
    localparam int PTE_W  = sv39pte_pkg::PTE_W;
    localparam int CNT_W  = sv39pte_pkg::COUNT_W;
    localparam int VA_W   = sv39pte_pkg::VA_W;
    localparam logic [USED_W-1:0] POOL_SIZE = USED_W'(TABLE_PAGES);
    localparam logic [VPN_W-1:0]  LAST_SLOT = VPN_W'(sv39pte_pkg::PT_ENTRIES - 1);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_CHECK = 6'b001000,
        S_ZERO  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [1:0]             level_reg, level_next;
    logic [PIDX_W-1:0]      page_reg, page_next;
    logic [PIDX_W-1:0]      new_page_reg, new_page_next;
    logic [USED_W-1:0]      used_reg, used_next;
    logic [VPN_W-1:0]       sweep_reg, sweep_next;
    logic [PPN_W-1:0]       base_reg, base_next;
    sv39pte_pkg::op_t       op_reg, op_next;
    logic [VA_W-1:0]        va_reg, va_next;
    logic [PPN_W-1:0]       ppn_reg, ppn_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       done_reg, done_next;
    logic [7:0]             perm_reg, perm_next;
    logic                   out_valid_reg, out_valid_next;
    sv39pte_pkg::pte_rsp_t  out_reg, out_next;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
    logic [PTE_W-1:0]       mem_wdata, mem_rdata;

    logic [VPN_W-1:0]       vpn;
    logic [ADDR_W-1:0]      slot_addr;
    logic [PPN_W-1:0]       off;
    logic                   off_bad;
    logic [CNT_W-1:0]       done_inc;
    sv39pte_pkg::status_t   walk_fail;

    sv39pte_ram #(
        .WIDTH  (PTE_W),
        .DEPTH  (TABLE_PAGES * sv39pte_pkg::PT_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_table_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        unique case (level_reg)
            2'd0:    vpn = va_reg[sv39pte_pkg::PAGE_SHIFT +: VPN_W];
            2'd1:    vpn = va_reg[sv39pte_pkg::PAGE_SHIFT + VPN_W +: VPN_W];
            default: vpn = va_reg[sv39pte_pkg::PAGE_SHIFT + 2 * VPN_W +: VPN_W];
        endcase
    end

    assign slot_addr = {page_reg, vpn};
    assign mem_raddr = slot_addr;
    assign off       = mem_rdata[sv39pte_pkg::PTE_PPN_SHIFT +: PPN_W] - base_reg;
    assign off_bad   = (off >= {{(PPN_W - USED_W){1'b0}}, used_reg});
    assign done_inc  = done_reg + CNT_W'(1);
    // a lookup reports a failed walk as simply not mapped
    assign walk_fail = (op_reg == sv39pte_pkg::OP_LOOKUP) ? sv39pte_pkg::ST_NOT_MAPPED
                                                          : sv39pte_pkg::ST_WALK_FAILED;

    assign s_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        page_next      = page_reg;
        new_page_next  = new_page_reg;
        used_next      = used_reg;
        sweep_next     = sweep_reg;
        base_next      = cfg_wr_en ? cfg_wr_data : base_reg;
        op_next        = op_reg;
        va_next        = va_reg;
        ppn_next       = ppn_reg;
        cnt_next       = cnt_reg;
        done_next      = done_reg;
        perm_next      = perm_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_addr;
        mem_wdata      = '0;

        unique case (state_reg)
            S_INIT: begin
                mem_we     = 1'b1;
                mem_waddr  = {{PIDX_W{1'b0}}, sweep_reg};
                sweep_next = sweep_reg + VPN_W'(1);
                if (sweep_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next    = s_data.op;
                    va_next    = s_data.virt_addr;
                    ppn_next   = s_data.phys_addr[sv39pte_pkg::PAGE_SHIFT +: PPN_W];
                    cnt_next   = s_data.page_count;
                    perm_next  = s_data.perm;
                    done_next  = '0;
                    level_next = 2'(sv39pte_pkg::LEVEL_TOP);
                    page_next  = '0;
                    out_next   = '0;
                    priority if (s_data.op == sv39pte_pkg::OP_LOOKUP) begin
                        state_next = S_READ;
                    end else if (s_data.op != sv39pte_pkg::OP_MAP &&
                                 s_data.op != sv39pte_pkg::OP_UNMAP) begin
                        out_valid_next = 1'b1;
                    end else if (s_data.virt_addr[sv39pte_pkg::PAGE_SHIFT-1:0] != '0) begin
                        out_next.status = sv39pte_pkg::ST_MISALIGNED;
                        out_valid_next  = 1'b1;
                    end else if (s_data.page_count == '0) begin
                        if (s_data.op == sv39pte_pkg::OP_MAP) begin
                            out_next.status = sv39pte_pkg::ST_ZERO_COUNT;
                        end
                        out_valid_next = 1'b1;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = S_READ;
                out_next   = '0;
                if (level_reg != 2'd0) begin
                    priority if (mem_rdata[0]) begin
                        if (off_bad) begin
                            out_next.status     = walk_fail;
                            out_next.pages_done = done_reg;
                            out_valid_next      = 1'b1;
                            state_next          = S_IDLE;
                        end else begin
                            page_next  = off[PIDX_W-1:0];
                            level_next = level_reg - 2'd1;
                        end
                    end else if (op_reg != sv39pte_pkg::OP_MAP) begin
                        out_next.status     = walk_fail;
                        out_next.pages_done = done_reg;
                        out_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end else if (used_reg >= POOL_SIZE) begin
                        out_next.status     = sv39pte_pkg::ST_NO_MEMORY;
                        out_next.pages_done = done_reg;
                        out_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end else begin
                        // link a fresh pool page, then clear it
                        mem_we        = 1'b1;
                        mem_wdata     = {{(PTE_W - PPN_W - sv39pte_pkg::PTE_PPN_SHIFT){1'b0}},
                                         base_reg + PPN_W'(used_reg),
                                         {(sv39pte_pkg::PTE_PPN_SHIFT - 1){1'b0}}, 1'b1};
                        new_page_next = used_reg[PIDX_W-1:0];
                        used_next     = used_reg + USED_W'(1);
                        sweep_next    = '0;
                        state_next    = S_ZERO;
                    end
                end else begin
                    unique case (op_reg)
                        sv39pte_pkg::OP_MAP: begin
                            if (mem_rdata[0]) begin
                                out_next.status     = sv39pte_pkg::ST_REMAP;
                                out_next.pages_done = done_reg;
                                out_valid_next      = 1'b1;
                                state_next          = S_IDLE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = {{(PTE_W - PPN_W - sv39pte_pkg::PTE_PPN_SHIFT){1'b0}},
                                             ppn_reg, 2'b00, perm_reg | 8'h01};
                                ppn_next  = ppn_reg + PPN_W'(1);
                            end
                        end
                        sv39pte_pkg::OP_UNMAP: begin
                            if (!mem_rdata[0]) begin
                                out_next.status     = sv39pte_pkg::ST_NOT_MAPPED;
                                out_next.pages_done = done_reg;
                                out_valid_next      = 1'b1;
                                state_next          = S_IDLE;
                            end else if (mem_rdata[9:0] == 10'd1) begin
                                out_next.status     = sv39pte_pkg::ST_NOT_LEAF;
                                out_next.pages_done = done_reg;
                                out_valid_next      = 1'b1;
                                state_next          = S_IDLE;
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = '0;
                            end
                        end
                        default: begin
                            if (!mem_rdata[0]) begin
                                out_next.status = sv39pte_pkg::ST_NOT_MAPPED;
                            end else begin
                                out_next.result_addr = {mem_rdata[sv39pte_pkg::PTE_PPN_SHIFT +:
                                                        PPN_W],
                                                        {sv39pte_pkg::PAGE_SHIFT{1'b0}}};
                            end
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    endcase
                    // a page done on map or unmap: step on or finish
                    if (mem_we) begin
                        done_next  = done_inc;
                        va_next    = va_reg + VA_W'(1 << sv39pte_pkg::PAGE_SHIFT);
                        level_next = 2'(sv39pte_pkg::LEVEL_TOP);
                        page_next  = '0;
                        if (done_inc == cnt_reg) begin
                            out_next.status     = sv39pte_pkg::ST_OK;
                            out_next.pages_done = done_inc;
                            out_valid_next      = 1'b1;
                            state_next          = S_IDLE;
                        end
                    end
                end
            end
            S_ZERO: begin
                mem_we     = 1'b1;
                mem_waddr  = {new_page_reg, sweep_reg};
                sweep_next = sweep_reg + VPN_W'(1);
                if (sweep_reg == LAST_SLOT) begin
                    page_next  = new_page_reg;
                    level_next = level_reg - 2'd1;
                    state_next = S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            used_reg      <= USED_W'(1);
            sweep_reg     <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            page_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            sweep_reg     <= sweep_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
            level_reg     <= level_next;
            page_reg      <= page_next;
        end
    end

    always_ff @(posedge aclk) begin
        new_page_reg <= new_page_next;
        op_reg       <= op_next;
        va_reg       <= va_next;
        ppn_reg      <= ppn_next;
        cnt_reg      <= cnt_next;
        done_reg     <= done_next;
        perm_reg     <= perm_next;
        out_reg      <= out_next;
    end

endmodule

/* verif/tb_sv39_page_table_engine_top.sv */
// Testbench for sv39_page_table_engine_top: random and directed map, unmap and
// lookup transactions checked against an in-bench page table predictor.
// Depends on sv39pte_pkg and the engine RTL.
module tb_sv39_page_table_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_PAGES    = 16;
    localparam int PPN_W         = sv39pte_pkg::PPN_W;
    localparam int PTE_W         = sv39pte_pkg::PTE_W;
    localparam int VA_W          = sv39pte_pkg::VA_W;
    localparam int PA_W          = sv39pte_pkg::PA_W;
    localparam int COUNT_W       = sv39pte_pkg::COUNT_W;
    localparam int PT_ENTRIES    = sv39pte_pkg::PT_ENTRIES;
    localparam int PAGE_SHIFT    = sv39pte_pkg::PAGE_SHIFT;
    localparam int PTE_PPN_SHIFT = sv39pte_pkg::PTE_PPN_SHIFT;
    localparam logic [PPN_W-1:0] PPN_ALL = {PPN_W{1'b1}};
    // reserved op code, answered with an all-zero result
    localparam sv39pte_pkg::op_t OP_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [PPN_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    sv39pte_pkg::pte_req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sv39pte_pkg::pte_rsp_t m_data;

    sv39_page_table_engine_top #(.TABLE_PAGES(POOL_PAGES)) i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // predictor state
    logic [PTE_W-1:0] pt_mem [POOL_PAGES*PT_ENTRIES];
    int unsigned      pool_used;
    logic [PPN_W-1:0] base_ppn;

    sv39pte_pkg::pte_req_t  pending_reqs[$];
    sv39pte_pkg::pte_rsp_t  expected_rsps[$];
    int        error_count = 0;
    bit        calm = 1'b0;
    bit        s_fire = 1'b0;
    int        s_idle = 0;
    int        m_idle = 0;

    function automatic logic [8:0] vpn_at(logic [VA_W-1:0] va, int lvl);
        return va[PAGE_SHIFT + 9*lvl +: 9];
    endfunction

    function automatic sv39pte_pkg::status_t walk_pt(logic [VA_W-1:0] va, bit alloc,
                                                     output int slot);
        int unsigned page;
        int unsigned idx;
        logic [PTE_W-1:0] e;
        logic [PPN_W-1:0] off;
        page = 0;
        slot = 0;
        for (int lvl = sv39pte_pkg::LEVEL_TOP; lvl > 0; lvl--) begin
            idx = page*PT_ENTRIES + vpn_at(va, lvl);
            e = pt_mem[idx];
            if (e[0]) begin
                off = e[PTE_PPN_SHIFT +: PPN_W] - base_ppn;
                if (off >= pool_used) return sv39pte_pkg::ST_WALK_FAILED;
                page = off;
            end else begin
                if (!alloc) return sv39pte_pkg::ST_WALK_FAILED;
                if (pool_used >= POOL_PAGES) return sv39pte_pkg::ST_NO_MEMORY;
                page = pool_used;
                pool_used++;
                for (int i = 0; i < PT_ENTRIES; i++) pt_mem[page*PT_ENTRIES + i] = '0;
                pt_mem[idx] = {10'd0, PPN_W'(base_ppn + page), 9'd0, 1'b1};
            end
        end
        slot = page*PT_ENTRIES + vpn_at(va, 0);
        return sv39pte_pkg::ST_OK;
    endfunction

    function automatic sv39pte_pkg::pte_rsp_t apply_request(sv39pte_pkg::pte_req_t rq);
        sv39pte_pkg::pte_rsp_t r;
        logic [VA_W-1:0] va;
        logic [PPN_W-1:0] ppn;
        int slot;
        sv39pte_pkg::status_t st;
        r = '0;
        va = rq.virt_addr;
        ppn = rq.phys_addr[PA_W-1:PAGE_SHIFT];
        case (rq.op)
            sv39pte_pkg::OP_MAP: begin
                if (va[11:0] != 0) r.status = sv39pte_pkg::ST_MISALIGNED;
                else if (rq.page_count == 0) r.status = sv39pte_pkg::ST_ZERO_COUNT;
                else begin
                    for (int k = 0; k < rq.page_count; k++) begin
                        st = walk_pt(va, 1'b1, slot);
                        if (st != sv39pte_pkg::ST_OK) begin
                            r.status = st;
                            break;
                        end
                        if (pt_mem[slot][0]) begin
                            r.status = sv39pte_pkg::ST_REMAP;
                            break;
                        end
                        pt_mem[slot] = {10'd0, ppn, 2'b00, rq.perm | 8'h01};
                        r.pages_done++;
                        va = va + (1 << PAGE_SHIFT);
                        ppn = ppn + 1;
                    end
                end
            end
            sv39pte_pkg::OP_UNMAP: begin
                if (va[11:0] != 0) r.status = sv39pte_pkg::ST_MISALIGNED;
                else begin
                    for (int k = 0; k < rq.page_count; k++) begin
                        if (walk_pt(va, 1'b0, slot) != sv39pte_pkg::ST_OK) begin
                            r.status = sv39pte_pkg::ST_WALK_FAILED;
                            break;
                        end
                        if (!pt_mem[slot][0]) begin
                            r.status = sv39pte_pkg::ST_NOT_MAPPED;
                            break;
                        end
                        if (pt_mem[slot][9:0] == 10'd1) begin
                            r.status = sv39pte_pkg::ST_NOT_LEAF;
                            break;
                        end
                        pt_mem[slot] = '0;
                        r.pages_done++;
                        va = va + (1 << PAGE_SHIFT);
                    end
                end
            end
            sv39pte_pkg::OP_LOOKUP: begin
                if (walk_pt(va, 1'b0, slot) != sv39pte_pkg::ST_OK || !pt_mem[slot][0])
                    r.status = sv39pte_pkg::ST_NOT_MAPPED;
                else
                    r.result_addr = {pt_mem[slot][PTE_PPN_SHIFT +: PPN_W], 12'd0};
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // input handshake taken at the rising edge, acted on at the next falling edge
    always @(posedge aclk) begin
        s_fire = aresetn && s_valid && s_ready;
    end

    // driver
    always @(negedge aclk) begin
        if (s_fire) begin
            expected_rsps.push_back(apply_request(s_data));
        end
        if (!s_valid || s_fire) begin
            if (s_idle > 0) begin
                s_idle--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_data <= pending_reqs.pop_front();
                s_valid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) s_idle = $urandom_range(1, 10);
            end else begin
                s_valid <= 1'b0;
            end
        end
        if (m_idle > 0) begin
            m_idle--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) m_idle = $urandom_range(1, 10);
        end
    end

    // monitor
    always @(posedge aclk) begin
        sv39pte_pkg::pte_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_data.result_addr), 0);
            end else begin
                want = expected_rsps.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch("status", m_data.status, want.status);
                if (m_data.result_addr !== want.result_addr)
                    report_mismatch("result_addr", m_data.result_addr, want.result_addr);
                if (m_data.pages_done !== want.pages_done)
                    report_mismatch("pages_done", m_data.pages_done, want.pages_done);
            end
        end
    end

    function automatic sv39pte_pkg::pte_req_t mk_req(sv39pte_pkg::op_t op,
                                                     logic [VA_W-1:0] va,
                                                     logic [PA_W-1:0] pa,
                                                     logic [COUNT_W-1:0] cnt,
                                                     logic [7:0] perm);
        sv39pte_pkg::pte_req_t rq;
        rq.op = op;
        rq.virt_addr = va;
        rq.phys_addr = pa;
        rq.page_count = cnt;
        rq.perm = perm;
        return rq;
    endfunction

    // random item biased to a small window of the address space so walks hit
    function automatic sv39pte_pkg::pte_req_t rand_req();
        sv39pte_pkg::pte_req_t rq;
        logic [VA_W-1:0] va;
        int sel;
        sel = $urandom_range(0, 9);
        va = VA_W'({$urandom, $urandom});
        if (sel < 8) begin
            va[38:30] = $urandom_range(0, 2) == 0 ? 9'h1FF : 9'(($urandom_range(0, 1)));
            va[29:21] = 9'($urandom_range(0, 3));
            va[20:12] = $urandom_range(0, 3) == 0 ? 9'h1FF - 9'($urandom_range(0, 3))
                                                   : 9'($urandom_range(0, 40));
            if ($urandom_range(0, 7) != 0) va[11:0] = '0;
        end
        rq.virt_addr = va;
        rq.phys_addr = PA_W'({$urandom, $urandom});
        rq.perm = 8'($urandom);
        rq.page_count = $urandom_range(0, 9) == 0 ? COUNT_W'({$urandom})
                                                 : COUNT_W'($urandom_range(0, 6));
        rq.op = $urandom_range(0, 19) == 0 ? OP_UNUSED
                                           : sv39pte_pkg::op_t'($urandom_range(0, 2));
        if (rq.op == sv39pte_pkg::OP_MAP && rq.page_count > 600)
            rq.page_count = COUNT_W'($urandom_range(1, 600));
        return rq;
    endfunction

    task automatic wait_drained(int extra);
        while (pending_reqs.size() > 0 || s_valid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_base(logic [PPN_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        base_ppn = v;
    endtask

    task automatic reset_pool();
        for (int i = 0; i < POOL_PAGES*PT_ENTRIES; i++) pt_mem[i] = '0;
        pool_used = 1;
    endtask

    initial begin
        logic [PPN_W-1:0] bases [4];
        reset_pool();
        base_ppn = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // directed
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_LOOKUP, '0, '0, 0, 0));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_MAP, 39'h123, '1, 1, 8'hFF));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_MAP, 39'h1000, '1, 0, 8'h00));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_MAP, 39'h7F_FFFF_E000, {PA_W{1'b1}}, 4,
                                      8'hFE));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_LOOKUP, 39'h7F_FFFF_FABC, '0, 0, 0));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_LOOKUP, 39'h0_0000_0ABC, '0, 0, 0));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_MAP, 39'h0, 56'hAB_CDEF_0000_1FFF, 2,
                                      8'h0E));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_MAP, 39'h1000, '0, 1, 8'h00));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_MAP, 39'h2000, '0, 1, 8'h00));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_UNMAP, 39'h2000, '0, 1, 0));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_UNMAP, 39'h0, '0, 0, 0));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_UNMAP, 39'h7, '0, 1, 0));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_UNMAP, 39'h0, '0, 5, 0));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_UNMAP, 39'h40_0000_0000, '0, 1, 0));
        pending_reqs.push_back(mk_req(OP_UNUSED, '1, '1, '1, 8'hFF));
        // inner entry at the leaf level via huge-address aliasing is not reachable; perm 0 leaf
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_MAP, 39'h5000, '0, 1, 8'h00));
        pending_reqs.push_back(mk_req(sv39pte_pkg::OP_UNMAP, 39'h5000, '0, 1, 0));
        // exhaust the pool
        for (int i = 0; i < 8; i++)
            pending_reqs.push_back(mk_req(sv39pte_pkg::OP_MAP, {9'(i + 2), 9'd0, 9'd0, 12'd0},
                                          '0, 1, 8'h02));
        wait_drained(20);
        // new pool base: old inner pointers go stale
        bases[0] = PPN_ALL; bases[1] = '0; bases[2] = 44'h5A5_A5A5_A5A5; bases[3] = 44'h1;
        for (int ph = 0; ph < 4; ph++) begin
            write_base(bases[ph]);
            pending_reqs.push_back(mk_req(sv39pte_pkg::OP_LOOKUP, 39'h7F_FFFF_E000, '0, 0, 0));
            pending_reqs.push_back(mk_req(sv39pte_pkg::OP_MAP, 39'h7F_FFFF_E000, '0, 1, 0));
            pending_reqs.push_back(mk_req(sv39pte_pkg::OP_UNMAP, 39'h7F_FFFF_E000, '0, 1, 0));
            for (int i = 0; i < 320; i++) pending_reqs.push_back(rand_req());
            if (ph == 3) calm = 1'b1;
            wait_drained(20);
        end
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/sv39pte_pkg.sv
hw/rtl/sv39pte_ram.sv
hw/rtl/sv39_page_table_engine_top.sv
verif/tb_sv39_page_table_engine_top.sv
